// ===== hw/rtl/kte_pkg.sv =====
// shared types and constants for the keyed entry table
package kte_pkg;

  localparam int unsigned DEF_NUM_SLOTS = 16;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned LIMIT_W       = 5;

  // list requests return at most this many entries
  localparam logic [LIMIT_W-1:0] MAX_RESULTS = 5'd16;

  // z value that asks for removal
  localparam logic signed [COORD_W-1:0] Z_REMOVE = -16'sd1;

  typedef enum logic [2:0] {
    ST_UPDATED        = 3'd0,
    ST_INSERTED       = 3'd1,
    ST_REMOVED        = 3'd2,
    ST_REMOVE_UNKNOWN = 3'd3,
    ST_DROPPED_FULL   = 3'd4,
    ST_LIST_ENTRY     = 3'd5
  } status_t;

  typedef struct packed {
    logic                      active;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } entry_t;

endpackage

// ===== hw/rtl/kte_req_if.sv =====
// request channel of the keyed entry table
interface kte_req_if import kte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ID_W-1:0]           obj_id;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [LIMIT_W-1:0]        list_limit;

  modport source (
    output valid, req_type, obj_id, pos_x, pos_y, pos_z, list_limit,
    input  ready
  );
  modport sink (
    input  valid, req_type, obj_id, pos_x, pos_y, pos_z, list_limit,
    output ready
  );
endinterface

// ===== hw/rtl/kte_rsp_if.sv =====
// result channel of the keyed entry table
interface kte_rsp_if import kte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic [SLOT_W-1:0]         slot;
  logic [ID_W-1:0]           out_id;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      entry_valid;
  logic                      last;

  modport source (
    output valid, status, slot, out_id, out_x, out_y, out_z, entry_valid, last,
    input  ready
  );
  modport sink (
    input  valid, status, slot, out_id, out_x, out_y, out_z, entry_valid, last,
    output ready
  );
endinterface

// ===== hw/rtl/kte_cell.sv =====
// one table cell: holds one entry and takes its neighbor's entry on shift
module kte_cell import kte_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift_en,
  input  entry_t ent_in,
  output entry_t ent_out
);

  logic   act_r;
  entry_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (shift_en) begin
      act_r <= ent_in.active;
    end
    if (shift_en) begin
      data_r <= ent_in;
    end
  end

  always_comb begin
    ent_out        = data_r;
    ent_out.active = act_r;
  end

endmodule

// ===== hw/rtl/kte_ring.sv =====
// ring of table cells; the head cell is visible, the tail takes the new entry
module kte_ring import kte_pkg::*; #(
  parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift_en,
  input  entry_t tail_in,
  output entry_t head
);

  entry_t link [NUM_SLOTS+1];

  assign link[NUM_SLOTS] = tail_in;
  assign head            = link[0];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    kte_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .ent_in   (link[g+1]),
      .ent_out  (link[g])
    );
  end

endmodule

// ===== hw/rtl/keyed_entry_table.sv =====
// keyed entry table: tracked objects in a rotating ring of cells
//
// Channels: in_ch carries one request per handshake (valid/ready). A report
// request (req_type 0) updates the active entry with the same obj_id, takes
// the lowest free slot, or with pos_z of -1 removes the matching entry; it
// always yields exactly one result with last set. A list request
// (req_type 1) yields every active entry in slot order, at most
// min(list_limit, 16), the final one marked last; with nothing to list a
// single empty result (entry_valid 0, last 1) is given.
// Timing: the table lives in NUM_SLOTS cells that rotate one place per cycle
// while a pass runs and no stall holds them, so a pass brings each slot once
// to the head cell. A report needs one search pass plus, when it writes or
// removes, one more pass to reach the target slot; a dropped report or the
// removal of an unknown id has no second pass. A list needs one pass; each
// entry leaves when the next is found. Requests are taken only in the idle
// state after an operation has put its final result in the output register,
// so a new request is never taken while the last one is still in progress.
// Stall: a list pass halts the ring while a newly found entry meets a held
// output register; the next request may enter while a result waits there.
// Reset: all slots become inactive at once; no clearing pass is needed.
module keyed_entry_table import kte_pkg::*; #(
  parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic clk,
  input  logic rst_n,
  kte_req_if.sink   in_ch,
  kte_rsp_if.source out_ch
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_LIST,
    S_FLUSH
  } state_t;

  // control
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               is_list_r, is_list_nxt;
  logic               hit_v_r, hit_v_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               free_v_r, free_v_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [LIMIT_W-1:0] count_r, count_nxt;
  logic [LIMIT_W-1:0] lim_r, lim_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [ID_W-1:0]           id_r, id_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt;
  logic signed [COORD_W-1:0] y_r, y_nxt;
  logic signed [COORD_W-1:0] z_r, z_nxt;
  logic [IDX_W-1:0]          target_r, target_nxt;
  logic                      rm_r, rm_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]         res_slot_r, res_slot_nxt;
  entry_t                    pend_ent_r, pend_ent_nxt;
  logic [SLOT_W-1:0]         pend_slot_r, pend_slot_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;
  entry_t                    out_ent_r, out_ent_nxt;
  logic                      out_last_r, out_last_nxt;

  // ring
  logic   shift_en;
  entry_t tail_in;
  entry_t head;

  logic last_step;
  logic out_free;
  logic hit_now, free_now, h_v, f_v, collect;
  logic [IDX_W-1:0] h_i, f_i;

  kte_ring #(.NUM_SLOTS(NUM_SLOTS)) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .tail_in  (tail_in),
    .head     (head)
  );

  assign last_step = (idx_r == LAST_IDX);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    is_list_nxt    = is_list_r;
    hit_v_nxt      = hit_v_r;
    hit_idx_nxt    = hit_idx_r;
    free_v_nxt     = free_v_r;
    free_idx_nxt   = free_idx_r;
    count_nxt      = count_r;
    lim_nxt        = lim_r;
    pend_v_nxt     = pend_v_r;
    id_nxt         = id_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    target_nxt     = target_r;
    rm_nxt         = rm_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    pend_ent_nxt   = pend_ent_r;
    pend_slot_nxt  = pend_slot_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_ent_nxt    = out_ent_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    shift_en       = 1'b0;
    tail_in        = head;
    hit_now        = head.active && (head.id == id_r);
    free_now       = !head.active;
    h_v            = hit_v_r;
    h_i            = hit_idx_r;
    f_v            = free_v_r;
    f_i            = free_idx_r;
    collect        = head.active && (count_r < lim_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          is_list_nxt = in_ch.req_type;
          id_nxt      = in_ch.obj_id;
          x_nxt       = in_ch.pos_x;
          y_nxt       = in_ch.pos_y;
          z_nxt       = in_ch.pos_z;
          lim_nxt     = (in_ch.list_limit > MAX_RESULTS) ? MAX_RESULTS : in_ch.list_limit;
          count_nxt   = '0;
          pend_v_nxt  = 1'b0;
          hit_v_nxt   = 1'b0;
          free_v_nxt  = 1'b0;
          state_nxt   = in_ch.req_type ? S_LIST : S_FIND;
        end
      end

      S_FIND: begin
        shift_en = 1'b1;
        idx_nxt  = last_step ? '0 : idx_r + IDX_W'(1);
        if (hit_now && !hit_v_r) begin
          h_v = 1'b1;
          h_i = idx_r;
        end
        if (free_now && !free_v_r) begin
          f_v = 1'b1;
          f_i = idx_r;
        end
        hit_v_nxt    = h_v;
        hit_idx_nxt  = h_i;
        free_v_nxt   = f_v;
        free_idx_nxt = f_i;
        if (last_step) begin
          rm_nxt = (z_r == Z_REMOVE);
          priority if (z_r == Z_REMOVE && h_v) begin
            res_status_nxt = ST_REMOVED;
            res_slot_nxt   = SLOT_W'(h_i);
            target_nxt     = h_i;
            state_nxt      = S_APPLY;
          end else if (z_r == Z_REMOVE) begin
            res_status_nxt = ST_REMOVE_UNKNOWN;
            res_slot_nxt   = '0;
            state_nxt      = S_FLUSH;
          end else if (h_v) begin
            res_status_nxt = ST_UPDATED;
            res_slot_nxt   = SLOT_W'(h_i);
            target_nxt     = h_i;
            state_nxt      = S_APPLY;
          end else if (f_v) begin
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = SLOT_W'(f_i);
            target_nxt     = f_i;
            state_nxt      = S_APPLY;
          end else begin
            res_status_nxt = ST_DROPPED_FULL;
            res_slot_nxt   = '0;
            state_nxt      = S_FLUSH;
          end
        end
      end

      S_APPLY: begin
        shift_en = 1'b1;
        idx_nxt  = last_step ? '0 : idx_r + IDX_W'(1);
        if (idx_r == target_r) begin
          if (rm_r) begin
            tail_in.active = 1'b0;
          end else begin
            tail_in = '{active: 1'b1, id: id_r, x: x_r, y: y_r, z: z_r};
          end
        end
        if (last_step) begin
          state_nxt = S_FLUSH;
        end
      end

      S_LIST: begin
        // hold the ring while a finished entry cannot leave
        if (!(collect && pend_v_r && !out_free)) begin
          shift_en = 1'b1;
          idx_nxt  = last_step ? '0 : idx_r + IDX_W'(1);
          if (collect) begin
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_LIST_ENTRY;
              out_slot_nxt   = pend_slot_r;
              out_ent_nxt    = pend_ent_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_ent_nxt  = head;
            pend_slot_nxt = SLOT_W'(idx_r);
            count_nxt     = count_r + LIMIT_W'(1);
          end
          if (last_step) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (is_list_r) begin
            out_status_nxt = ST_LIST_ENTRY;
            out_slot_nxt   = pend_v_r ? pend_slot_r : '0;
            out_ent_nxt    = pend_v_r ? pend_ent_r : '0;
          end else begin
            out_status_nxt = res_status_r;
            out_slot_nxt   = res_slot_r;
            out_ent_nxt    = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      is_list_r   <= 1'b0;
      hit_v_r     <= 1'b0;
      hit_idx_r   <= '0;
      free_v_r    <= 1'b0;
      free_idx_r  <= '0;
      count_r     <= '0;
      lim_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      is_list_r   <= is_list_nxt;
      hit_v_r     <= hit_v_nxt;
      hit_idx_r   <= hit_idx_nxt;
      free_v_r    <= free_v_nxt;
      free_idx_r  <= free_idx_nxt;
      count_r     <= count_nxt;
      lim_r       <= lim_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r         <= id_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    z_r          <= z_nxt;
    target_r     <= target_nxt;
    rm_r         <= rm_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    pend_ent_r   <= pend_ent_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ent_r    <= out_ent_nxt;
    out_last_r   <= out_last_nxt;
  end

  // result register drives the channel directly
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.out_id      = out_ent_r.id;
  assign out_ch.out_x       = out_ent_r.x;
  assign out_ch.out_y       = out_ent_r.y;
  assign out_ch.out_z       = out_ent_r.z;
  assign out_ch.entry_valid = out_ent_r.active;
  assign out_ch.last        = out_last_r;

  // ring is back in its home position whenever the block waits for a request
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> idx_r == '0)
    else $error("ring not aligned while idle");

  // a list never collects more entries than its limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lim_r)
    else $error("list count beyond limit");

  // a held-back list entry only exists during a list pass or its flush
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_LIST || state_r == S_FLUSH))
    else $error("pending entry outside list");

  // a stalled list pass does not move the ring
  a_list_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST && pend_v_r && collect && !out_free) |=> $stable(idx_r))
    else $error("ring moved during stall");

endmodule

// ===== sim/tb.sv =====
// testbench for keyed_entry_table: directed table, then random traffic against a shadow table
module tb;
  import kte_pkg::*;

  localparam int unsigned SLOTS           = DEF_NUM_SLOTS;
  localparam int          CLK_PERIOD      = 8;
  localparam int          RESET_CYCLES    = 12;
  localparam int          RANDOM_ITEMS    = 184;
  localparam int          ID_POOL_SIZE    = 24;
  localparam int          HOLD_OFF_AFTER  = 120;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 2 * SLOTS + 8;
  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          MAX_REPORTED    = 10;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_LIST   = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [ID_W-1:0]           obj_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [LIMIT_W-1:0]        list_limit;
  } request_t;

  typedef struct packed {
    status_t                   status;
    logic [SLOT_W-1:0]         slot;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      entry_valid;
    logic                      last;
  } result_t;

  // one stimulus row; where typed is set the row gives exactly one empty result
  typedef struct packed {
    request_t          request;
    logic              typed;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kte_req_if in_ch ();
  kte_rsp_if out_ch ();

  keyed_entry_table #(.NUM_SLOTS(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the table and the results still owed by the block
  entry_t          shadow [SLOTS];
  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];
  result_t         step_results [$];
  result_t         pending_results [$];
  logic            send_burst   = 1'b0;
  logic            held_off     = 1'b0;
  int              results_seen = 0;
  int              mismatches   = 0;
  int              idle_cycles  = 0;

  function automatic stim_row_t stim_row(logic rt, int id, int x, int y, int z, int lim,
                                         logic typed, status_t st, int sl);
    stim_row_t r;
    r.request.req_type   = rt;
    r.request.obj_id     = ID_W'(id);
    r.request.pos_x      = COORD_W'(x);
    r.request.pos_y      = COORD_W'(y);
    r.request.pos_z      = COORD_W'(z);
    r.request.list_limit = LIMIT_W'(lim);
    r.typed              = typed;
    r.status             = st;
    r.slot               = SLOT_W'(sl);
    return r;
  endfunction

  // applies one request to the shadow table, leaves its results in step_results
  function automatic void track_request(request_t r);
    int      hit;
    int      free_slot;
    int      active_cnt;
    int      to_list;
    int      listed;
    result_t res;
    hit        = -1;
    free_slot  = -1;
    active_cnt = 0;
    listed     = 0;
    res        = '0;
    res.last   = 1'b1;
    step_results.delete();
    if (r.req_type == REQ_REPORT) begin
      // first matching active slot wins; free slot only counts below the match
      for (int i = 0; i < SLOTS && hit < 0; i++) begin
        if (shadow[i].active && shadow[i].id == r.obj_id) hit = i;
        else if (!shadow[i].active && free_slot < 0) free_slot = i;
      end
      if (r.pos_z == Z_REMOVE) begin
        if (hit >= 0) begin
          shadow[hit].active = 1'b0;
          res.status         = ST_REMOVED;
          res.slot           = SLOT_W'(hit);
        end else begin
          res.status = ST_REMOVE_UNKNOWN;
        end
      end else if (hit >= 0 || free_slot >= 0) begin
        if (hit >= 0) begin
          res.status = ST_UPDATED;
        end else begin
          res.status = ST_INSERTED;
          hit        = free_slot;
        end
        shadow[hit].active = 1'b1;
        shadow[hit].id     = r.obj_id;
        shadow[hit].x      = r.pos_x;
        shadow[hit].y      = r.pos_y;
        shadow[hit].z      = r.pos_z;
        res.slot           = SLOT_W'(hit);
      end else begin
        res.status = ST_DROPPED_FULL;
      end
      step_results.push_back(res);
    end else begin
      to_list = (r.list_limit > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(r.list_limit);
      for (int i = 0; i < SLOTS; i++) if (shadow[i].active) active_cnt++;
      if (active_cnt < to_list) to_list = active_cnt;
      res.status = ST_LIST_ENTRY;
      if (to_list == 0) begin
        step_results.push_back(res);
      end else begin
        for (int i = 0; i < SLOTS && listed < to_list; i++) begin
          if (shadow[i].active) begin
            res.slot        = SLOT_W'(i);
            res.id          = shadow[i].id;
            res.x           = shadow[i].x;
            res.y           = shadow[i].y;
            res.z           = shadow[i].z;
            res.entry_valid = 1'b1;
            res.last        = (listed == to_list - 1);
            step_results.push_back(res);
            listed++;
          end
        end
      end
    end
  endfunction

  // mostly reports on a small id pool so that updates, removals and a full table occur
  function automatic request_t random_request();
    request_t r;
    int       pick;
    r.req_type   = REQ_REPORT;
    r.obj_id     = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
    r.pos_x      = COORD_W'($urandom);
    r.pos_y      = COORD_W'($urandom);
    r.pos_z      = COORD_W'($urandom);
    r.list_limit = LIMIT_W'($urandom);
    pick         = $urandom_range(0, 99);
    if (pick < 20) r.req_type = REQ_LIST;
    else if (pick < 35) r.pos_z = Z_REMOVE;
    else if (pick < 45) r.obj_id = ID_W'($urandom);
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("status %0d slot %0d id %h x %h y %h z %h valid %b last %b",
                     r.status, r.slot, r.id, r.x, r.y, r.z, r.entry_valid, r.last);
  endfunction

  // offers one request, waits for the handshake, then books its results
  task automatic issue_row(stim_row_t row);
    result_t typed_res;
    int      gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= row.request.req_type;
    in_ch.obj_id     <= row.request.obj_id;
    in_ch.pos_x      <= row.request.pos_x;
    in_ch.pos_y      <= row.request.pos_y;
    in_ch.pos_z      <= row.request.pos_z;
    in_ch.list_limit <= row.request.list_limit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_request(row.request);
    if (row.typed) begin
      typed_res        = '0;
      typed_res.status = row.status;
      typed_res.slot   = row.slot;
      typed_res.last   = 1'b1;
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[j]) pending_results.push_back(step_results[j]);
    end
  endtask

  // request side: reset, directed table, random traffic, then drain and verdict
  initial begin
    stim_row_t rows [$];
    stim_row_t rnd_row;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_REPORT;
    in_ch.obj_id     <= '0;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.pos_z      <= '0;
    in_ch.list_limit <= '0;
    rst_n            <= 1'b0;
    foreach (shadow[i]) shadow[i] = '0;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 65535));

    // empty table, unknown removal, extreme coordinates and ids
    rows.push_back(stim_row(REQ_LIST, 0, 0, 0, 0, 16, 1'b1, ST_LIST_ENTRY, 0));
    rows.push_back(stim_row(REQ_REPORT, 'h1234, 7, 9, -1, 0, 1'b1, ST_REMOVE_UNKNOWN, 0));
    rows.push_back(stim_row(REQ_REPORT, 0, -32768, 32767, 0, 0, 1'b1, ST_INSERTED, 0));
    rows.push_back(stim_row(REQ_REPORT, 'hFFFF, 32767, -32768, 32767, 31,
                            1'b1, ST_INSERTED, 1));
    rows.push_back(stim_row(REQ_REPORT, 0, 'h5555, 'hAAAA, -32768, 0, 1'b1, ST_UPDATED, 0));
    // zero limit lists nothing, limit one lists the first entry
    rows.push_back(stim_row(REQ_LIST, 'hFFFF, -1, -1, -1, 0, 1'b1, ST_LIST_ENTRY, 0));
    rows.push_back(stim_row(REQ_LIST, 0, 0, 0, 0, 1, 1'b0, ST_LIST_ENTRY, 0));
    // removal leaves a hole that the next new id takes
    rows.push_back(stim_row(REQ_REPORT, 'hFFFF, 0, 0, -1, 0, 1'b1, ST_REMOVED, 1));
    rows.push_back(stim_row(REQ_REPORT, 'h00FF, 'h0100, -256, 1, 0, 1'b1, ST_INSERTED, 1));
    for (int k = 2; k < SLOTS; k++) begin
      rows.push_back(stim_row(REQ_REPORT, 'h1000 + k, k * 256, -k * 128, k, 0,
                              1'b1, ST_INSERTED, k));
    end
    // full table: new id dropped, known id still updated, saturated limit lists all
    rows.push_back(stim_row(REQ_REPORT, 'hBEEF, 1, 2, 5, 0, 1'b1, ST_DROPPED_FULL, 0));
    rows.push_back(stim_row(REQ_REPORT, 'h00FF, -5, 5, 2, 0, 1'b1, ST_UPDATED, 1));
    rows.push_back(stim_row(REQ_LIST, 0, 0, 0, 0, 31, 1'b0, ST_LIST_ENTRY, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) issue_row(rows[k]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rnd_row         = '0;
      rnd_row.request = random_request();
      issue_row(rnd_row);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, compare with the oldest expectation
  initial begin
    result_t got;
    result_t want;
    logic    take_burst;
    int      gap;
    take_burst = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 11);
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        // long stall so the block backs up into its request side
        held_off = 1'b1;
        gap      = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.status      = out_ch.status;
      got.slot        = out_ch.slot;
      got.id          = out_ch.out_id;
      got.x           = out_ch.out_x;
      got.y           = out_ch.out_y;
      got.z           = out_ch.out_z;
      got.entry_valid = out_ch.entry_valid;
      got.last        = out_ch.last;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED) $display("unexpected result: %s", show(got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot || got.id !== want.id ||
            got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.entry_valid !== want.entry_valid || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED) begin
            $display("result %0d mismatch\n  expected %s\n  actual   %s",
                     results_seen, show(want), show(got));
          end
        end
      end
    end
  end

  // ends a hung run: too many cycles in a row without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
